### src/whpu_pkg.sv
// Shared types and constants for the WAV header parser / 2x upsampler.
package whpu_pkg;

   // little-endian chunk ids as they appear after four bytes are shifted in
   localparam logic [31:0] ID_RIFF      = 32'h4646_4952;
   localparam logic [31:0] ID_FMT       = 32'h2074_6d66;
   localparam logic [31:0] ID_DATA      = 32'h6174_6164;
   localparam logic [31:0] FMT_EXT_SIZE = 32'd18;
   localparam logic [15:0] BYTE_BITS    = 16'd8;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_ERROR  = 2'd2
   } whpu_kind_type;

   typedef struct packed {
      whpu_kind_type kind;
      logic [7:0]    sample;
      logic          last;
      logic [31:0]   rate_hz;
      logic [15:0]   channel_count;
      logic [15:0]   bit_depth;
      logic [31:0]   bytes_per_second;
      logic [15:0]   format_code;
      logic [30:0]   data_length;
      logic          upsampling;
      logic          unsigned_8bit;
   } whpu_rsp_type;

   // results of one request, handed from the parser to the result queue
   typedef struct packed {
      logic [1:0]   count;
      whpu_rsp_type first;
      whpu_rsp_type second;
   } whpu_push_type;

endpackage

### src/whpu_ifs.sv
// Request and response channel interfaces.
interface whpu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       start_of_file;

   modport source (output valid, file_byte, start_of_file, input ready);
   modport sink   (input valid, file_byte, start_of_file, output ready);
endinterface

interface whpu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  sample;
   logic        last;
   logic [31:0] rate_hz;
   logic [15:0] channel_count;
   logic [15:0] bit_depth;
   logic [31:0] bytes_per_second;
   logic [15:0] format_code;
   logic [30:0] data_length;
   logic        upsampling;
   logic        unsigned_8bit;

   modport source (output valid, kind, sample, last, rate_hz, channel_count, bit_depth,
                   bytes_per_second, format_code, data_length, upsampling,
                   unsigned_8bit, input ready);
   modport sink   (input valid, kind, sample, last, rate_hz, channel_count, bit_depth,
                   bytes_per_second, format_code, data_length, upsampling,
                   unsigned_8bit, output ready);
endinterface

### src/whpu_parse.sv
// Chunk parser: parse state, header capture, rate check and sample interpolation.
module whpu_parse
   import whpu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  logic [7:0]    file_byte,
   input  logic          start_of_file,
   output whpu_push_type push
);

   typedef enum logic [15:0] {
      PH_ID         = 16'h0001,
      PH_RIFF_A     = 16'h0002,
      PH_RIFF_B     = 16'h0004,
      PH_FMT_SIZE   = 16'h0008,
      PH_FMT_FORMAT = 16'h0010,
      PH_FMT_CHAN   = 16'h0020,
      PH_FMT_RATE   = 16'h0040,
      PH_FMT_BRATE  = 16'h0080,
      PH_FMT_ALIGN  = 16'h0100,
      PH_FMT_BITS   = 16'h0200,
      PH_FMT_CB     = 16'h0400,
      PH_SKIP_SIZE  = 16'h0800,
      PH_SKIP       = 16'h1000,
      PH_DATA_SIZE  = 16'h2000,
      PH_DATA       = 16'h4000,
      PH_DONE       = 16'h8000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  biw_ff, biw_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] fmt_size_ff, fmt_size_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] chan_ff, chan_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] format_ff, format_in;
   logic [30:0] remain_ff, remain_in;
   logic [7:0]  prev_ff, prev_in;
   logic        first_ff, first_in;
   logic [31:0] adopted_ff, adopted_in;
   logic        upsample_ff, upsample_in;
   logic        halted_ff, halted_in;

   always_comb begin
      logic [31:0]  word4;
      logic [15:0]  word2;
      logic         done2;
      logic         done4;
      logic         bad;
      logic         is_last;
      logic [8:0]   pair_sum;
      whpu_rsp_type info;

      phase_in    = phase_ff;
      biw_in      = biw_ff;
      shift_in    = shift_ff;
      skip_in     = skip_ff;
      fmt_size_in = fmt_size_ff;
      rate_in     = rate_ff;
      brate_in    = brate_ff;
      chan_in     = chan_ff;
      bits_in     = bits_ff;
      format_in   = format_ff;
      remain_in   = remain_ff;
      prev_in     = prev_ff;
      first_in    = first_ff;
      adopted_in  = adopted_ff;
      upsample_in = upsample_ff;
      halted_in   = halted_ff;
      push        = '0;
      word4       = {file_byte, shift_ff[31:8]};
      word2       = word4[31:16];
      done2       = (biw_ff != 2'd0);
      done4       = (biw_ff == 2'd3);
      bad         = 1'b0;
      is_last     = 1'b0;
      pair_sum    = 9'd0;
      info        = '0;

      if (item_valid) begin
         // new file: clear everything but the adopted rate
         if (start_of_file) begin
            phase_in    = PH_ID;
            biw_in      = 2'd0;
            shift_in    = 32'd0;
            skip_in     = 32'd0;
            fmt_size_in = 32'd0;
            rate_in     = 32'd0;
            brate_in    = 32'd0;
            chan_in     = 16'd0;
            bits_in     = 16'd0;
            format_in   = 16'd0;
            remain_in   = 31'd0;
            prev_in     = 8'd0;
            first_in    = 1'b1;
            upsample_in = 1'b0;
            halted_in   = 1'b0;
         end
         word4 = {file_byte, shift_in[31:8]};
         word2 = word4[31:16];
         done2 = (biw_in != 2'd0);
         done4 = (biw_in == 2'd3);

         if (!halted_in) begin
            unique case (phase_in)
               PH_ID, PH_RIFF_A, PH_RIFF_B, PH_FMT_SIZE, PH_FMT_RATE, PH_FMT_BRATE,
               PH_SKIP_SIZE, PH_DATA_SIZE: begin
                  shift_in = word4;
                  biw_in   = done4 ? 2'd0 : biw_in + 2'd1;
               end
               PH_FMT_FORMAT, PH_FMT_CHAN, PH_FMT_ALIGN, PH_FMT_BITS, PH_FMT_CB: begin
                  shift_in = word4;
                  biw_in   = done2 ? 2'd0 : biw_in + 2'd1;
               end
               default: begin
               end
            endcase

            unique case (phase_in)
               PH_ID: begin
                  if (done4) begin
                     priority if (word4 == ID_RIFF) phase_in = PH_RIFF_A;
                     else if (word4 == ID_FMT)      phase_in = PH_FMT_SIZE;
                     else if (word4 == ID_DATA)     phase_in = PH_DATA_SIZE;
                     else                           phase_in = PH_SKIP_SIZE;
                  end
               end
               PH_RIFF_A: begin
                  if (done4) phase_in = PH_RIFF_B;
               end
               PH_RIFF_B: begin
                  if (done4) phase_in = PH_ID;
               end
               PH_FMT_SIZE: begin
                  if (done4) begin
                     fmt_size_in = word4;
                     phase_in    = PH_FMT_FORMAT;
                  end
               end
               PH_FMT_FORMAT: begin
                  if (done2) begin
                     format_in = word2;
                     phase_in  = PH_FMT_CHAN;
                  end
               end
               PH_FMT_CHAN: begin
                  if (done2) begin
                     chan_in  = word2;
                     phase_in = PH_FMT_RATE;
                  end
               end
               PH_FMT_RATE: begin
                  if (done4) begin
                     rate_in  = word4;
                     phase_in = PH_FMT_BRATE;
                  end
               end
               PH_FMT_BRATE: begin
                  if (done4) begin
                     brate_in = word4;
                     phase_in = PH_FMT_ALIGN;
                  end
               end
               PH_FMT_ALIGN: begin
                  if (done2) phase_in = PH_FMT_BITS;
               end
               PH_FMT_BITS: begin
                  if (done2) begin
                     bits_in  = word2;
                     phase_in = (fmt_size_in == FMT_EXT_SIZE) ? PH_FMT_CB : PH_ID;
                  end
               end
               PH_FMT_CB: begin
                  if (done2) begin
                     skip_in  = {16'd0, word2};
                     phase_in = (word2 == 16'd0) ? PH_ID : PH_SKIP;
                  end
               end
               PH_SKIP_SIZE: begin
                  if (done4) begin
                     skip_in  = word4;
                     phase_in = (word4 == 32'd0) ? PH_ID : PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_in - 32'd1;
                  if (skip_in == 32'd0) phase_in = PH_ID;
               end
               PH_DATA_SIZE: begin
                  if (done4) begin
                     if (word4[31]) begin
                        // oversized length: not data, look for the next chunk
                        phase_in = PH_ID;
                     end else begin
                        remain_in   = word4[30:0];
                        upsample_in = 1'b0;
                        priority if (adopted_in == 32'd0) adopted_in = rate_in;
                        else if (adopted_in == rate_in) upsample_in = 1'b0;
                        else if ({1'b0, adopted_in} == {rate_in, 1'b0}) upsample_in = 1'b1;
                        else bad = 1'b1;

                        info.rate_hz          = rate_in;
                        info.channel_count    = chan_in;
                        info.bit_depth        = bits_in;
                        info.bytes_per_second = brate_in;
                        info.format_code      = format_in;
                        info.data_length      = remain_in;
                        info.unsigned_8bit    = (bits_in == BYTE_BITS);

                        push.first            = info;
                        push.first.kind       = KIND_HEADER;
                        push.first.upsampling = upsample_in;
                        push.count            = 2'd1;
                        if (bad) begin
                           push.second      = info;
                           push.second.kind = KIND_ERROR;
                           push.count       = 2'd2;
                           upsample_in      = 1'b0;
                           halted_in        = 1'b1;
                           phase_in         = PH_DONE;
                        end else begin
                           first_in = 1'b1;
                           phase_in = (word4 == 32'd0) ? PH_DONE : PH_DATA;
                        end
                     end
                  end
               end
               PH_DATA: begin
                  is_last  = (remain_in == 31'd1);
                  pair_sum = {1'b0, prev_in} + {1'b0, file_byte};
                  if (upsample_in && !first_in) begin
                     push.first.kind   = KIND_SAMPLE;
                     push.first.sample = pair_sum[8:1];
                     push.second.kind  = KIND_SAMPLE;
                     push.second.sample = file_byte;
                     push.second.last  = is_last;
                     push.count        = 2'd2;
                  end else begin
                     push.first.kind   = KIND_SAMPLE;
                     push.first.sample = file_byte;
                     push.first.last   = is_last;
                     push.count        = 2'd1;
                  end
                  first_in  = 1'b0;
                  prev_in   = file_byte;
                  remain_in = remain_in - 31'd1;
                  if (is_last) phase_in = PH_DONE;
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_ID;
         biw_ff      <= 2'd0;
         shift_ff    <= 32'd0;
         skip_ff     <= 32'd0;
         fmt_size_ff <= 32'd0;
         rate_ff     <= 32'd0;
         brate_ff    <= 32'd0;
         chan_ff     <= 16'd0;
         bits_ff     <= 16'd0;
         format_ff   <= 16'd0;
         remain_ff   <= 31'd0;
         prev_ff     <= 8'd0;
         first_ff    <= 1'b1;
         adopted_ff  <= 32'd0;
         upsample_ff <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         biw_ff      <= biw_in;
         shift_ff    <= shift_in;
         skip_ff     <= skip_in;
         fmt_size_ff <= fmt_size_in;
         rate_ff     <= rate_in;
         brate_ff    <= brate_in;
         chan_ff     <= chan_in;
         bits_ff     <= bits_in;
         format_ff   <= format_in;
         remain_ff   <= remain_in;
         prev_ff     <= prev_in;
         first_ff    <= first_in;
         adopted_ff  <= adopted_in;
         upsample_ff <= upsample_in;
         halted_ff   <= halted_in;
      end
   end

   // a halted parser sits in the done phase until the next file
   a_halt_done: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> phase_ff == PH_DONE)
      else $error("halted outside done phase");

   // a rate error never leaves upsampling on
   a_halt_no_up: assert property (@(posedge clock) disable iff (reset)
      !(halted_ff && upsample_ff))
      else $error("upsampling active while halted");

   // responses only come out of a parsed request
   a_push_needs_item: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> item_valid)
      else $error("responses without a parsed request");

endmodule

### src/whpu_queue.sv
// Result queue: takes up to two results a cycle, hands out one.
module whpu_queue
   import whpu_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  whpu_push_type push,
   input  logic          pop,
   output whpu_rsp_type  head,
   output logic          not_empty,
   output logic          has_room
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   whpu_rsp_type  entry_ff [DEPTH];
   logic [IW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] wr_next;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + IW'(1);
   endfunction

   assign wr_next   = wrap_inc(wr_ff);
   assign head      = entry_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign has_room  = (cnt_ff <= ROOM_MAX);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff + CW'(push.count);
      unique case (push.count)
         2'd1:    wr_in = wr_next;
         2'd2:    wr_in = wrap_inc(wr_next);
         default: wr_in = wr_ff;
      endcase
      if (pop) begin
         rd_in  = wrap_inc(rd_ff);
         cnt_in = cnt_in - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> has_room)
      else $error("results pushed without room for two");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> cnt_ff == $past(cnt_ff) - CW'(1))
      else $error("queue count wrong after pop");

endmodule

### src/wav_header_parse_upsample.sv
// WAV header parser with 2x upsampling: top level.
// Path: a request is registered in the input register, parsed once the queue has room,
//   and its responses are written into the result queue and offered from its head.
// Throughput: one request per cycle while each gives at most one response and the queue
//   has room; an upsampled byte gives two responses through the single response port.
// Reset (synchronous, active high): parser back to chunk-id search, no rate adopted,
//   input register and response queue emptied.
module wav_header_parse_upsample
   import whpu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   whpu_req_if.sink          req_bus,
   whpu_rsp_if.source        rsp_bus
);

   // input register: holds one request until the queue can take its responses
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_sof_ff, in_sof_in;

   logic          q_room;
   logic          q_not_empty;
   logic          advance;
   logic          req_take;
   logic          rsp_take;
   whpu_push_type push;
   whpu_rsp_type  head;

   // parse the held request only when the queue has room for two responses
   assign advance  = in_valid_ff && q_room;
   assign req_bus.ready = !in_valid_ff || q_room;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_sof_in   = in_sof_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.file_byte;
         in_sof_in   = req_bus.start_of_file;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_sof_ff  <= in_sof_in;
   end

   whpu_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (advance),
      .file_byte     (in_byte_ff),
      .start_of_file (in_sof_ff),
      .push          (push)
   );

   whpu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_take),
      .head      (head),
      .not_empty (q_not_empty),
      .has_room  (q_room)
   );

   // response side is driven straight from the queue's head entry
   assign rsp_take                 = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid            = q_not_empty;
   assign rsp_bus.kind             = head.kind;
   assign rsp_bus.sample           = head.sample;
   assign rsp_bus.last             = head.last;
   assign rsp_bus.rate_hz          = head.rate_hz;
   assign rsp_bus.channel_count    = head.channel_count;
   assign rsp_bus.bit_depth        = head.bit_depth;
   assign rsp_bus.bytes_per_second = head.bytes_per_second;
   assign rsp_bus.format_code      = head.format_code;
   assign rsp_bus.data_length      = head.data_length;
   assign rsp_bus.upsampling       = head.upsampling;
   assign rsp_bus.unsigned_8bit    = head.unsigned_8bit;

endmodule

### dv/tb_wav_header_parse_upsample.sv
// Testbench for the WAV header parser / 2x upsampler: directed table, then random files.
`timescale 1ns / 100ps

module tb_wav_header_parse_upsample;
   import whpu_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 450;   // accepted requests per phase
   localparam int unsigned STALL_LIMIT     = 2000;  // cycles with no handshake at all
   localparam int unsigned HOLD_CYCLES     = 120;   // long receiver hold-off in the last phase
   localparam int unsigned DRAIN_CYCLES    = 20;    // settle time once nothing is due
   localparam int          UNTYPED         = -1;    // row result comes from the parser model
   localparam logic [31:0] ID_WAVE         = 32'h4556_4157;

   // where the byte parser stands in the stream
   typedef enum logic [3:0] {
      AT_CHUNK_ID, AT_RIFF_SIZE, AT_RIFF_FORM, AT_FMT_SIZE, AT_FMT_TAG, AT_FMT_CHANNELS,
      AT_FMT_RATE, AT_FMT_BYTE_RATE, AT_FMT_ALIGN, AT_FMT_BITS, AT_FMT_EXTRA,
      AT_SKIP_SIZE, AT_SKIPPING, AT_DATA_SIZE, AT_DATA, AT_FINISHED
   } parse_step_type;

   typedef struct {
      logic [7:0]   file_byte;
      logic         start_of_file;
      int           typed_count;   // UNTYPED, or number of results typed in below
      whpu_rsp_type typed_first;
      whpu_rsp_type typed_second;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   whpu_req_if req_bus ();
   whpu_rsp_if rsp_bus ();

   wav_header_parse_upsample dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Parser model: own copy of the stream state
   // ---------------------------------------------------------------------------
   parse_step_type step;
   logic [1:0]     word_pos;
   logic [31:0]    shift_word;
   logic [31:0]    bytes_to_skip;
   logic [31:0]    fmt_size;
   logic [31:0]    rate;
   logic [31:0]    bytes_per_sec;
   logic [15:0]    channels;
   logic [15:0]    bits;
   logic [15:0]    format;
   logic [30:0]    bytes_left;
   logic [7:0]     prev_byte;
   bit             first_pending;
   bit             upsample_on;
   bit             stopped;
   logic [31:0]    locked_rate;     // survives a new file, cleared only by reset
   bit             request_ignored; // last parsed byte had no effect at all

   whpu_rsp_type step_results[$];   // results of the byte just parsed
   whpu_rsp_type results_due[$];    // results still owed by the block, oldest first

   // everything but the adopted rate starts over on a new file
   task automatic restart_parse();
      step          = AT_CHUNK_ID;
      word_pos      = '0;
      shift_word    = '0;
      bytes_to_skip = '0;
      fmt_size      = '0;
      rate          = '0;
      bytes_per_sec = '0;
      channels      = '0;
      bits          = '0;
      format        = '0;
      bytes_left    = '0;
      prev_byte     = '0;
      first_pending = 1'b1;
      upsample_on   = 1'b0;
      stopped       = 1'b0;
   endtask

   // little-endian shift-in; returns 1 once a word of width bytes is complete
   function automatic bit take_word(input logic [7:0] b, input int unsigned width,
                                    output logic [31:0] value);
      shift_word = {b, shift_word[31:8]};
      value      = (width == 4) ? shift_word : {16'h0000, shift_word[31:16]};
      if (word_pos + 1 >= width) begin
         word_pos = '0;
         return 1'b1;
      end
      word_pos = word_pos + 2'd1;
      return 1'b0;
   endfunction

   function automatic whpu_rsp_type info_rsp(input whpu_kind_type kind, input bit up);
      whpu_rsp_type r = '0;
      r.kind             = kind;
      r.rate_hz          = rate;
      r.channel_count    = channels;
      r.bit_depth        = bits;
      r.bytes_per_second = bytes_per_sec;
      r.format_code      = format;
      r.data_length      = bytes_left;
      r.upsampling       = up;
      r.unsigned_8bit    = (bits == BYTE_BITS);
      return r;
   endfunction

   function automatic whpu_rsp_type sample_rsp(input logic [7:0] s, input logic last);
      whpu_rsp_type r = '0;
      r.kind   = KIND_SAMPLE;
      r.sample = s;
      r.last   = last;
      return r;
   endfunction

   // header with nothing captured: what a file without a fmt chunk reports
   function automatic whpu_rsp_type bare_header(input logic [30:0] length);
      whpu_rsp_type r = '0;
      r.kind        = KIND_HEADER;
      r.data_length = length;
      return r;
   endfunction

   task automatic parse_wav_byte(input logic [7:0] b, input logic sof);
      logic [31:0] word;
      logic [8:0]  pair_sum;
      bit          done;
      bit          mismatch;
      bit          final_byte;
      step_results.delete();
      if (sof) restart_parse();
      request_ignored = stopped || (step == AT_FINISHED);
      if (request_ignored) return;

      case (step)
         AT_SKIPPING, AT_DATA: done = 1'b0;
         AT_FMT_TAG, AT_FMT_CHANNELS, AT_FMT_ALIGN, AT_FMT_BITS, AT_FMT_EXTRA: begin
            done = take_word(b, 2, word);
         end
         default: done = take_word(b, 4, word);
      endcase

      case (step)
         AT_CHUNK_ID: if (done) begin
            if (word == ID_RIFF) step = AT_RIFF_SIZE;
            else if (word == ID_FMT) step = AT_FMT_SIZE;
            else if (word == ID_DATA) step = AT_DATA_SIZE;
            else step = AT_SKIP_SIZE;
         end
         AT_RIFF_SIZE: if (done) step = AT_RIFF_FORM;
         AT_RIFF_FORM: if (done) step = AT_CHUNK_ID;
         AT_FMT_SIZE: if (done) begin
            fmt_size = word;
            step     = AT_FMT_TAG;
         end
         AT_FMT_TAG: if (done) begin
            format = word[15:0];
            step   = AT_FMT_CHANNELS;
         end
         AT_FMT_CHANNELS: if (done) begin
            channels = word[15:0];
            step     = AT_FMT_RATE;
         end
         AT_FMT_RATE: if (done) begin
            rate = word;
            step = AT_FMT_BYTE_RATE;
         end
         AT_FMT_BYTE_RATE: if (done) begin
            bytes_per_sec = word;
            step          = AT_FMT_ALIGN;
         end
         AT_FMT_ALIGN: if (done) step = AT_FMT_BITS;
         AT_FMT_BITS: if (done) begin
            bits = word[15:0];
            // only an 18-byte fmt body carries the extra count
            step = (fmt_size == FMT_EXT_SIZE) ? AT_FMT_EXTRA : AT_CHUNK_ID;
         end
         AT_FMT_EXTRA, AT_SKIP_SIZE: if (done) begin
            bytes_to_skip = word;
            step = (word == 0) ? AT_CHUNK_ID : AT_SKIPPING;
         end
         AT_SKIPPING: begin
            bytes_to_skip = bytes_to_skip - 32'd1;
            if (bytes_to_skip == 0) step = AT_CHUNK_ID;
         end
         AT_DATA_SIZE: if (done) begin
            if (word[31]) begin
               // oversized data length: not data, look for the next chunk
               step = AT_CHUNK_ID;
            end else begin
               mismatch    = 1'b0;
               bytes_left  = word[30:0];
               upsample_on = 1'b0;
               if (locked_rate == 0) locked_rate = rate;
               else if (locked_rate == rate) upsample_on = 1'b0;
               else if ({1'b0, locked_rate} == {rate, 1'b0}) upsample_on = 1'b1;
               else mismatch = 1'b1;
               step_results.push_back(info_rsp(KIND_HEADER, upsample_on));
               if (mismatch) begin
                  step_results.push_back(info_rsp(KIND_ERROR, 1'b0));
                  upsample_on = 1'b0;
                  stopped     = 1'b1;
                  step        = AT_FINISHED;
               end else begin
                  first_pending = 1'b1;
                  step = (word == 0) ? AT_FINISHED : AT_DATA;
               end
            end
         end
         AT_DATA: begin
            final_byte = (bytes_left == 31'd1);
            if (upsample_on && !first_pending) begin
               pair_sum = {1'b0, prev_byte} + {1'b0, b};
               step_results.push_back(sample_rsp(pair_sum[8:1], 1'b0));
               step_results.push_back(sample_rsp(b, final_byte));
            end else begin
               step_results.push_back(sample_rsp(b, final_byte));
            end
            first_pending = 1'b0;
            prev_byte     = b;
            bytes_left    = bytes_left - 31'd1;
            if (final_byte) step = AT_FINISHED;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Random file builder
   // ---------------------------------------------------------------------------
   logic [7:0] file_data[$];
   bit         file_sof[$];
   bit         open_file;   // next byte pushed carries the start marker

   task automatic push_byte(input logic [7:0] b);
      file_data.push_back(b);
      file_sof.push_back(open_file);
      open_file = 1'b0;
   endtask

   task automatic push_word(input logic [31:0] value, input int unsigned nbytes);
      for (int i = 0; i < nbytes; i++) push_byte(value[8*i +: 8]);
   endtask

   // unknown chunk, usually with a short body, now and then a huge size that
   // swallows the rest of the file
   task automatic push_other_chunk();
      logic [31:0] size;
      push_word($urandom, 4);
      size = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 5);
      push_word(size, 4);
      if (size <= 5) repeat (size) push_byte(8'($urandom_range(255)));
   endtask

   // rate seen against what the block has adopted so far
   function automatic logic [31:0] pick_rate();
      int unsigned roll;
      roll = $urandom_range(99);
      if (locked_rate == 0) begin
         if (roll < 15) return 32'd0;
         if (roll < 40) return 32'd44100;
         if (roll < 60) return 32'd48000;
         return 2 * $urandom_range(1, 100000);
      end
      if (roll < 40) return locked_rate;
      if (roll < 70) return locked_rate >> 1;
      if (roll < 80) return (locked_rate >> 1) | 32'h8000_0000;  // doubling would wrap
      if (roll < 85) return locked_rate << 1;
      if (roll < 95) return $urandom;
      return 32'd0;
   endfunction

   task automatic build_file();
      int unsigned style;
      int unsigned roll;
      int unsigned count;
      int unsigned cut;
      logic [31:0] size;
      logic [31:0] extra;
      file_data.delete();
      file_sof.delete();
      style = $urandom_range(99);
      if (style < 6) begin
         // pure noise with the odd stray start marker
         count = $urandom_range(1, 30);
         repeat (count) begin
            open_file = ($urandom_range(15) == 0);
            push_byte(8'($urandom_range(255)));
         end
         return;
      end
      // a few files just run on from the previous stream, without a marker
      open_file = (style >= 10);

      if ($urandom_range(3) != 0) begin
         push_word(ID_RIFF, 4);
         push_word($urandom, 4);
         push_word(ID_WAVE, 4);
      end
      if ($urandom_range(4) == 0) push_other_chunk();

      if ($urandom_range(9) != 0) begin
         push_word(ID_FMT, 4);
         roll = $urandom_range(99);
         if (roll < 50) size = 32'd16;
         else if (roll < 85) size = FMT_EXT_SIZE;
         else if (roll < 95) size = $urandom_range(0, 40);
         else size = $urandom;
         push_word(size, 4);
         push_word(($urandom_range(1) == 0) ? 32'd1 : $urandom, 2);
         push_word(($urandom_range(1) == 0) ? $urandom_range(1, 2) : $urandom, 2);
         push_word(pick_rate(), 4);
         push_word($urandom, 4);
         push_word($urandom, 2);
         push_word(($urandom_range(2) != 0) ? 32'd8 : $urandom, 2);
         if (size == FMT_EXT_SIZE) begin
            extra = ($urandom_range(9) == 0) ? ($urandom & 32'h0000_FFFF) : $urandom_range(0, 4);
            push_word(extra, 2);
            if (extra <= 4) repeat (extra) push_byte(8'($urandom_range(255)));
         end
      end

      if ($urandom_range(4) == 0) push_other_chunk();
      if ($urandom_range(11) == 0) begin
         push_word(ID_DATA, 4);
         push_word(32'h8000_0000 | $urandom, 4);
      end

      push_word(ID_DATA, 4);
      roll = $urandom_range(99);
      if (roll < 70) size = $urandom_range(0, 10);
      else if (roll < 85) size = $urandom_range(11, 40);
      else size = $urandom & 32'h7FFF_FFFF;   // long data, cut off by the next file
      push_word(size, 4);
      count = (size > 40) ? $urandom_range(0, 6) : size;
      repeat (count) push_byte(8'($urandom_range(255)));
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)));

      // broken file: cut short anywhere
      if ($urandom_range(19) == 0) begin
         cut = $urandom_range(1, file_data.size());
         while (file_data.size() > cut) begin
            file_data.pop_back();
            file_sof.pop_back();
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Request driver (changes on the falling edge)
   // ---------------------------------------------------------------------------
   int unsigned  sender_idle_pct;
   int unsigned  receiver_idle_pct;
   bit           hold_request;
   int           typed_count = UNTYPED;
   whpu_rsp_type typed_first;
   whpu_rsp_type typed_second;

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic sof, input int count,
                            input whpu_rsp_type first, input whpu_rsp_type second);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      typed_count  = count;
      typed_first  = first;
      typed_second = second;
      req_bus.valid         <= 1'b1;
      req_bus.file_byte     <= b;
      req_bus.start_of_file <= sof;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: ready pattern plus the long hold-off
   // ---------------------------------------------------------------------------
   int unsigned hold_left = 0;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted response
   // ---------------------------------------------------------------------------
   int unsigned fail_count    = 0;
   int unsigned counted_items = 0;
   int unsigned stall_cycles  = 0;

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_response(input whpu_rsp_type got);
      whpu_rsp_type want;
      if (results_due.size() == 0) begin
         fail_count++;
         $display("%0t: response with none expected, expected nothing actual %h", $time, got);
         return;
      end
      want = results_due.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("sample", 32'(want.sample), 32'(got.sample));
      compare_field("last", 32'(want.last), 32'(got.last));
      compare_field("rate_hz", want.rate_hz, got.rate_hz);
      compare_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
      compare_field("bit_depth", 32'(want.bit_depth), 32'(got.bit_depth));
      compare_field("bytes_per_second", want.bytes_per_second, got.bytes_per_second);
      compare_field("format_code", 32'(want.format_code), 32'(got.format_code));
      compare_field("data_length", 32'(want.data_length), 32'(got.data_length));
      compare_field("upsampling", 32'(want.upsampling), 32'(got.upsampling));
      compare_field("unsigned_8bit", 32'(want.unsigned_8bit), 32'(got.unsigned_8bit));
   endtask

   always @(posedge clock) begin : monitor
      bit           progressed;
      whpu_rsp_type got;
      if (!reset) begin
         progressed = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            progressed = 1'b1;
            // the model always runs so its state stays in step with the block
            parse_wav_byte(req_bus.file_byte, req_bus.start_of_file);
            counted_items++;
            if (typed_count == UNTYPED) begin
               foreach (step_results[i]) results_due.push_back(step_results[i]);
            end else begin
               if (typed_count > 0) results_due.push_back(typed_first);
               if (typed_count > 1) results_due.push_back(typed_second);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            progressed           = 1'b1;
            got.kind             = whpu_kind_type'(rsp_bus.kind);
            got.sample           = rsp_bus.sample;
            got.last             = rsp_bus.last;
            got.rate_hz          = rsp_bus.rate_hz;
            got.channel_count    = rsp_bus.channel_count;
            got.bit_depth        = rsp_bus.bit_depth;
            got.bytes_per_second = rsp_bus.bytes_per_second;
            got.format_code      = rsp_bus.format_code;
            got.data_length      = rsp_bus.data_length;
            got.upsampling       = rsp_bus.upsampling;
            got.unsigned_8bit    = rsp_bus.unsigned_8bit;
            check_response(got);
         end
         stall_cycles = progressed ? 0 : stall_cycles + 1;
      end
   end

   // no handshake on either side for too long: the block is stuck
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   stim_row_type directed_rows[$];

   task automatic add_row(input logic [7:0] b, input logic sof, input int count,
                          input whpu_rsp_type first, input whpu_rsp_type second);
      stim_row_type row;
      row.file_byte     = b;
      row.start_of_file = sof;
      row.typed_count   = count;
      row.typed_first   = first;
      row.typed_second  = second;
      directed_rows.push_back(row);
   endtask

   initial begin : stimulus
      int unsigned phase_target;
      req_bus.valid         = 1'b0;
      req_bus.file_byte     = '0;
      req_bus.start_of_file = 1'b0;
      rsp_bus.ready         = 1'b0;
      reset                 = 1'b1;
      hold_request          = 1'b0;
      sender_idle_pct       = 16;
      receiver_idle_pct     = 68;
      restart_parse();
      locked_rate = '0;

      // file made of a zero-length data chunk only: no fmt, header all zeros,
      // and rate 0 leaves the block unadopted
      add_row(8'h64, 1'b1, UNTYPED, '0, '0);
      add_row(8'h61, 1'b0, UNTYPED, '0, '0);
      add_row(8'h74, 1'b0, UNTYPED, '0, '0);
      add_row(8'h61, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, 1, bare_header(31'd0), '0);
      // byte after the data: ignored
      add_row(8'hFF, 1'b0, 0, '0, '0);
      // new file; data size with the top bit set is not data
      add_row(8'h64, 1'b1, UNTYPED, '0, '0);
      add_row(8'h61, 1'b0, UNTYPED, '0, '0);
      add_row(8'h74, 1'b0, UNTYPED, '0, '0);
      add_row(8'h61, 1'b0, UNTYPED, '0, '0);
      add_row(8'hFF, 1'b0, UNTYPED, '0, '0);
      add_row(8'hFF, 1'b0, UNTYPED, '0, '0);
      add_row(8'hFF, 1'b0, UNTYPED, '0, '0);
      add_row(8'hFF, 1'b0, 0, '0, '0);
      // then a real two-byte data chunk, extreme sample values
      add_row(8'h64, 1'b0, UNTYPED, '0, '0);
      add_row(8'h61, 1'b0, UNTYPED, '0, '0);
      add_row(8'h74, 1'b0, UNTYPED, '0, '0);
      add_row(8'h61, 1'b0, UNTYPED, '0, '0);
      add_row(8'h02, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, UNTYPED, '0, '0);
      add_row(8'h00, 1'b0, 1, bare_header(31'd2), '0);
      add_row(8'hFF, 1'b0, 1, sample_rsp(8'hFF, 1'b0), '0);
      add_row(8'h00, 1'b0, 1, sample_rsp(8'h00, 1'b1), '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].file_byte, directed_rows[i].start_of_file,
                   directed_rows[i].typed_count, directed_rows[i].typed_first,
                   directed_rows[i].typed_second);
      end

      // three random phases: slow receiver, slow sender, then full rate with
      // one long receiver hold-off so the block backs up into its input
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 16;
               receiver_idle_pct = 68;
            end
            1: begin
               sender_idle_pct   = 68;
               receiver_idle_pct = 16;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               hold_request      = 1'b1;
            end
         endcase
         phase_target = counted_items + ITEMS_PER_PHASE;
         while (counted_items < phase_target) begin
            build_file();
            foreach (file_data[i]) send_byte(file_data[i], file_sof[i], UNTYPED, '0, '0);
         end
         // sender pauses until the block has delivered everything owed
         req_bus.valid <= 1'b0;
         do @(negedge clock); while (results_due.size() != 0);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### wav_header_parse_upsample.f
src/whpu_pkg.sv
src/whpu_ifs.sv
src/whpu_parse.sv
src/whpu_queue.sv
src/wav_header_parse_upsample.sv
dv/tb_wav_header_parse_upsample.sv
